// File: rtl/core/ptrb_pkg.sv
package ptrb_pkg;

   // Ring geometry
   localparam int BUFFER_DEPTH = 258;
   localparam int ADDR_W       = 9;
   localparam int CNT_W        = 9;

   // Result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SEQ  = 2'd2;

   typedef enum logic [1:0] {
      FUNC_BEGIN     = 2'd0,
      FUNC_PAYLOAD   = 2'd1,
      FUNC_SEND_DONE = 2'd2,
      FUNC_READ      = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATE_IDLE  = 2'd0,
      STATE_EXEC  = 2'd1,
      STATE_ISSUE = 2'd2,
      STATE_REPLY = 2'd3
   } state_type;

   typedef struct packed {
      func_type    func;
      logic [7:0]  packet_type;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
      logic [8:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       send_issued;
      logic [8:0] send_start;
      logic [8:0] send_length;
      logic [7:0] read_data;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic issue;
   } ctrl_cmd_type;

endpackage

// File: rtl/core/ptrb_ctrl.sv
module ptrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_strobe,
   output ptrb_pkg::ctrl_cmd_type cmd
);
   import ptrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request: capture, execute, issue check, reply
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      rsp_strobe  = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            // hold off requests while reset is applied
            busy        = reset;
            cmd.capture = start && !reset;
            if (start && !reset) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = STATE_ISSUE;
         end
         STATE_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = STATE_REPLY;
         end
         STATE_REPLY: begin
            rsp_strobe = 1'b1;
            state_in   = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/ptrb_datapath.sv
module ptrb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ptrb_pkg::ctrl_cmd_type cmd,
   input  ptrb_pkg::req_type      req_data,
   output ptrb_pkg::rsp_type      rsp_data
);
   import ptrb_pkg::*;

   localparam logic [ADDR_W:0]  DEPTH_X  = (ADDR_W + 1)'(BUFFER_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BUFFER_DEPTH);
   localparam logic [16:0]      DEPTH_17 = 17'(BUFFER_DEPTH);

   logic [7:0] mem [BUFFER_DEPTH];

   req_type            req_ff;
   req_type            req_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   inflight_ff, inflight_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         rdata_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               mem_we;
   logic [7:0]         mem_wdata;
   logic [ADDR_W:0]    tail_sum;
   logic [ADDR_W-1:0]  tail;
   logic [ADDR_W:0]    head_sum;
   logic [ADDR_W-1:0]  head_wrap;
   logic [16:0]        need;
   logic               room_short;
   logic               read_ok;
   logic [CNT_W-1:0]   room_to_end;
   logic [CNT_W-1:0]   chunk_len;
   logic               issue_now;

   // Wrapping tail and retire positions
   assign tail_sum  = {1'b0, head_ff} + {1'b0, fill_ff};
   assign tail      = (tail_sum >= DEPTH_X) ? ADDR_W'(tail_sum - DEPTH_X)
                                             : tail_sum[ADDR_W-1:0];
   assign head_sum  = {1'b0, head_ff} + {1'b0, inflight_ff};
   assign head_wrap = (head_sum >= DEPTH_X) ? ADDR_W'(head_sum - DEPTH_X)
                                             : head_sum[ADDR_W-1:0];

   // Space check for a begin request: type byte plus payload
   assign need       = 17'(fill_ff) + 17'd1 + {1'b0, req_ff.payload_length};
   assign room_short = need > DEPTH_17;
   assign read_ok    = {1'b0, req_ff.read_index} < DEPTH_X;

   // Chunk that may go out now, cut at the buffer end
   assign room_to_end = DEPTH_C - head_ff;
   assign chunk_len   = (fill_ff > room_to_end) ? room_to_end : fill_ff;
   assign issue_now   = (status_ff == STATUS_OK) && (req_ff.func != FUNC_READ) &&
                        (inflight_ff == '0) && (remain_ff == '0) && (chunk_len != '0);

   // Next state of the queue
   always_comb begin
      req_in      = req_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      inflight_in = inflight_ff;
      remain_in   = remain_ff;
      status_in   = status_ff;
      rsp_in      = rsp_ff;
      mem_we      = 1'b0;
      mem_wdata   = req_ff.data_byte;
      if (cmd.capture) begin
         req_in = req_data;
      end
      if (cmd.execute) begin
         status_in = STATUS_OK;
         unique case (req_ff.func)
            FUNC_BEGIN: begin
               if (remain_ff != '0) begin
                  status_in = STATUS_SEQ;
               end else if (room_short) begin
                  status_in = STATUS_FULL;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = req_ff.packet_type;
                  fill_in   = fill_ff + 1'b1;
                  remain_in = req_ff.payload_length[CNT_W-1:0];
               end
            end
            FUNC_PAYLOAD: begin
               if (remain_ff == '0) begin
                  status_in = STATUS_SEQ;
               end else begin
                  mem_we    = 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  remain_in = remain_ff - 1'b1;
               end
            end
            FUNC_SEND_DONE: begin
               if (inflight_ff == '0) begin
                  status_in = STATUS_SEQ;
               end else begin
                  head_in     = head_wrap;
                  fill_in     = fill_ff - inflight_ff;
                  inflight_in = '0;
               end
            end
            FUNC_READ: begin
               if (!read_ok) begin
                  status_in = STATUS_SEQ;
               end
            end
            default: begin
               status_in = STATUS_SEQ;
            end
         endcase
      end
      // Build the reply; send a chunk if link free, packet done
      if (cmd.issue) begin
         rsp_in.status      = status_ff;
         rsp_in.send_issued = issue_now;
         rsp_in.send_start  = issue_now ? head_ff : '0;
         rsp_in.send_length = issue_now ? chunk_len : '0;
         rsp_in.read_data   = ((req_ff.func == FUNC_READ) && (status_ff == STATUS_OK))
                              ? rdata_ff : 8'd0;
         if (issue_now) begin
            inflight_in = chunk_len;
         end
      end
   end

   // Queue pointers and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         inflight_ff <= '0;
         remain_ff   <= '0;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         inflight_ff <= inflight_in;
         remain_ff   <= remain_in;
      end
   end

   // Request, status and reply registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // Byte store: write at the tail, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail] <= mem_wdata;
      end
      if (cmd.execute && read_ok) begin
         rdata_ff <= mem[req_ff.read_index[ADDR_W-1:0]];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/core/packet_tx_ring_buffer.sv
// Transmit ring buffer for a byte link.
// Requests enter on req_data when start is high and busy is low. The func
// field selects begin packet, payload byte, send done or read stored byte.
// Each request gives exactly one response on rsp_data, shown for a single
// cycle with rsp_strobe high; the receiver must take it then, it cannot stall.
// Sequence: after the edge that accepts a request the controller steps through
// execute, chunk check and reply, and the response strobe is high in the reply
// step; busy stays high until the response strobe has gone, so a new request
// is not taken before the last one has been answered. The queue update,
// including the byte store write or registered read, and the chunk check that
// uses the updated pointers each take a step of their own.
// Reset clears the pointers, the fill count, the in-flight length and the
// payload count; the byte store keeps whatever it holds and is valid only
// where written. Busy is high while reset is held, and the first request may
// be given in the cycle after reset.
module packet_tx_ring_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptrb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ptrb_pkg::rsp_type rsp_data
);
   import ptrb_pkg::*;

   ctrl_cmd_type cmd;

   // Sequencer
   ptrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // Queue state and byte store
   ptrb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// File: sim/packet_tx_ring_buffer_tb.sv
`timescale 1ns / 100ps

module packet_tx_ring_buffer_tb;
   import ptrb_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int DRAIN_LIMIT  = 200;

   // Ring model: tracks queue pointers and byte contents, predicts each response
   class ring_scoreboard;
      logic [7:0]  store [BUFFER_DEPTH];
      bit          written [BUFFER_DEPTH];
      int unsigned head;
      int unsigned fill;
      int unsigned in_flight;
      int unsigned remaining;
      rsp_type     expected_q [$];
      int unsigned errors;
      int unsigned requests_seen;
      int unsigned useful;
      int unsigned rejected_full;
      int unsigned ignored_items;
      int unsigned reads_done;
      int unsigned chunks_issued;
      int unsigned chunks_cut;

      function new();
         foreach (store[i]) begin
            store[i]   = '0;
            written[i] = 1'b0;
         end
         head          = 0;
         fill          = 0;
         in_flight     = 0;
         remaining     = 0;
         errors        = 0;
         requests_seen = 0;
         useful        = 0;
         rejected_full = 0;
         ignored_items = 0;
         reads_done    = 0;
         chunks_issued = 0;
         chunks_cut    = 0;
      endfunction

      // Append one byte at the wrapping tail
      function void append_byte(logic [7:0] value);
         int unsigned tail;
         tail          = (head + fill) % BUFFER_DEPTH;
         store[tail]   = value;
         written[tail] = 1'b1;
         fill++;
      endfunction

      // Start a new chunk when nothing is outstanding; cut it at the ring end
      function void start_chunk(inout rsp_type rsp);
         int unsigned to_end;
         int unsigned count;
         if (in_flight == 0 && remaining == 0) begin
            to_end = BUFFER_DEPTH - head;
            count  = (fill > to_end) ? to_end : fill;
            if (count != 0) begin
               in_flight        = count;
               rsp.send_issued  = 1'b1;
               rsp.send_start   = head[8:0];
               rsp.send_length  = count[8:0];
               chunks_issued++;
               if (fill > to_end)
                  chunks_cut++;
            end
         end
      endfunction

      function void note_request(req_type req);
         rsp_type rsp;
         rsp        = '0;
         rsp.status = STATUS_OK;
         case (req.func)
            FUNC_BEGIN: begin
               if (remaining != 0)
                  rsp.status = STATUS_SEQ;
               else if (fill + 1 + int'(req.payload_length) > BUFFER_DEPTH)
                  rsp.status = STATUS_FULL;
               else begin
                  append_byte(req.packet_type);
                  remaining = 32'(req.payload_length);
                  start_chunk(rsp);
               end
            end
            FUNC_PAYLOAD: begin
               if (remaining == 0)
                  rsp.status = STATUS_SEQ;
               else begin
                  append_byte(req.data_byte);
                  remaining--;
                  start_chunk(rsp);
               end
            end
            FUNC_SEND_DONE: begin
               if (in_flight == 0)
                  rsp.status = STATUS_SEQ;
               else begin
                  head      = (head + in_flight) % BUFFER_DEPTH;
                  fill      = fill - in_flight;
                  in_flight = 0;
                  start_chunk(rsp);
               end
            end
            default: begin
               if (req.read_index >= BUFFER_DEPTH)
                  rsp.status = STATUS_SEQ;
               else begin
                  rsp.read_data = store[req.read_index];
                  reads_done++;
               end
            end
         endcase
         requests_seen++;
         if (rsp.status == STATUS_SEQ)
            ignored_items++;
         else
            useful++;
         if (rsp.status == STATUS_FULL)
            rejected_full++;
         expected_q.push_back(rsp);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, got status %0d issued %0b",
                     $time, got.status, got.send_issued);
            return;
         end
         want = expected_q.pop_front();
         check_field("status", 16'(want.status), 16'(got.status));
         check_field("send_issued", 16'(want.send_issued), 16'(got.send_issued));
         check_field("send_start", 16'(want.send_start), 16'(got.send_start));
         check_field("send_length", 16'(want.send_length), 16'(got.send_length));
         check_field("read_data", 16'(want.read_data), 16'(got.read_data));
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   ring_scoreboard sb;
   bit             brim_done = 1'b0;
   int unsigned    cycles = 0;

   packet_tx_ring_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("** packet_tx_ring_buffer: FAILED **");
         $finish;
      end
   end

   // Check every strobed response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_response(rsp_data);
   end

   function automatic req_type make_request(func_type func, logic [7:0] ptype,
                                            logic [15:0] plen, logic [7:0] dbyte,
                                            logic [8:0] ridx);
      req_type req;
      req.func           = func;
      req.packet_type    = ptype;
      req.payload_length = plen;
      req.data_byte      = dbyte;
      req.read_index     = ridx;
      return req;
   endfunction

   // Pick a position that was written, or a position past the ring end
   function automatic logic [8:0] pick_index();
      int unsigned idx;
      if ($urandom_range(0, 99) < 15)
         return 9'($urandom_range(BUFFER_DEPTH, 511));
      repeat (16) begin
         idx = $urandom_range(0, BUFFER_DEPTH - 1);
         if (sb.written[idx])
            return 9'(idx);
      end
      return 9'($urandom_range(BUFFER_DEPTH, 511));
   endfunction

   // Build the next request from the current ring state
   function automatic req_type next_request();
      req_type     req;
      int unsigned roll;
      int unsigned pick;
      int unsigned drain_pct;
      int          free_room;
      req.func           = FUNC_READ;
      req.packet_type    = 8'($urandom);
      req.payload_length = 16'($urandom);
      req.data_byte      = 8'($urandom);
      req.read_index     = pick_index();
      roll      = $urandom_range(0, 99);
      free_room = BUFFER_DEPTH - 1 - int'(sb.fill);
      // alternate windows of fast and slow draining so the ring fills up
      drain_pct = ((sb.useful % 100) < 50) ? 30 : 3;
      if (sb.remaining != 0) begin
         if (roll < 80)
            req.func = FUNC_PAYLOAD;
         else if (roll < 88)
            req.func = FUNC_SEND_DONE;
         else if (roll < 95)
            req.func = FUNC_READ;
         else
            req.func = FUNC_BEGIN;
      end else if (!brim_done && sb.fill == 0) begin
         // fill the whole ring with one packet
         req.func           = FUNC_BEGIN;
         req.payload_length = 16'(free_room);
         brim_done          = 1'b1;
      end else if (roll < drain_pct) begin
         req.func = FUNC_SEND_DONE;
      end else if (roll < drain_pct + 15) begin
         req.func = FUNC_READ;
      end else if (roll < drain_pct + 18) begin
         req.func = FUNC_PAYLOAD;
      end else begin
         req.func = FUNC_BEGIN;
         pick     = $urandom_range(0, 99);
         if (free_room >= 0) begin
            if (pick < 3)
               req.payload_length = 16'(free_room + 1);
            else if (pick < 8)
               req.payload_length = 16'($urandom_range(free_room + 1, 65535));
            else if (pick < 12)
               req.payload_length = 16'(free_room);
            else
               req.payload_length = 16'($urandom_range(0, (free_room < 24) ? free_room : 24));
         end
      end
      return req;
   endfunction

   // Present one request, hold it until taken, then idle at random
   task automatic send_request(input req_type item, input int unsigned idle_pct);
      req_data <= item;
      start    <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      sb.note_request(item);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   initial begin
      int unsigned idle_plan [3];
      int unsigned target;
      int unsigned waited;
      idle_plan = '{0, 50, 8};
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: out-of-sequence items, size extremes, zero-length packet
      send_request(make_request(FUNC_READ, 8'h00, 16'h0000, 8'h00, 9'd300), 0);
      send_request(make_request(FUNC_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF, 9'd511), 0);
      send_request(make_request(FUNC_SEND_DONE, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_BEGIN, 8'hFF, 16'hFFFF, 8'h00, 9'd511), 0);
      send_request(make_request(FUNC_BEGIN, 8'hA5, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_BEGIN, 8'h3C, 16'h0002, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_BEGIN, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_SEND_DONE, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'hFF, 9'd258), 0);
      send_request(make_request(FUNC_READ, 8'h00, 16'h0000, 8'h00, 9'd0), 0);
      send_request(make_request(FUNC_READ, 8'hFF, 16'hFFFF, 8'hFF, 9'd3), 0);
      send_request(make_request(FUNC_READ, 8'h00, 16'h0000, 8'h00, 9'd511), 0);
      send_request(make_request(FUNC_SEND_DONE, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_BEGIN, 8'h55, 16'h0001, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_PAYLOAD, 8'h00, 16'h0000, 8'hAA, 9'd258), 0);
      send_request(make_request(FUNC_BEGIN, 8'h0F, 16'h0100, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_READ, 8'h00, 16'h0000, 8'h00, 9'd5), 0);
      send_request(make_request(FUNC_SEND_DONE, 8'h00, 16'h0000, 8'h00, 9'd258), 0);
      send_request(make_request(FUNC_SEND_DONE, 8'h00, 16'h0000, 8'h00, 9'd258), 0);

      // Random: one pass per sender idling plan
      foreach (idle_plan[p]) begin
         target = sb.useful + RANDOM_ITEMS / 3;
         while (sb.useful < target)
            send_request(next_request(), idle_plan[p]);
      end
      start <= 1'b0;

      // Drain outstanding responses, then watch for strays
      waited = 0;
      while (sb.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (sb.expected_q.size() != 0) begin
         sb.errors += sb.expected_q.size();
         $display("%0t: %0d responses never arrived", $time, sb.expected_q.size());
      end
      repeat (8) @(posedge clock);

      $display("Ran %0d requests (%0d ignored, %0d rejected for room, %0d reads).",
               sb.requests_seen, sb.ignored_items, sb.rejected_full, sb.reads_done);
      $display("Issued %0d transmit chunks, %0d of them cut at the ring end.",
               sb.chunks_issued, sb.chunks_cut);
      if (sb.errors == 0)
         $display("** packet_tx_ring_buffer: PASSED **");
      else
         $display("** packet_tx_ring_buffer: FAILED **");
      $finish;
   end

endmodule
